FILE: sv/tksr_pkg.sv
// shared constants, codes and item types of the two-key string record sorter
package tksr_pkg;

    localparam int MAX_RECORDS = 128;
    localparam int MAX_CHARS   = 1024;
    localparam int REC_W       = $clog2(MAX_RECORDS);
    localparam int POS_W       = $clog2(MAX_CHARS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int ADDR_W      = REC_W + POS_W;
    localparam int STORE_DEPTH = MAX_RECORDS * MAX_CHARS;

    // fixed field widths of the request and result items
    localparam int KIND_W   = 2;
    localparam int RECF_W   = 7;
    localparam int POSF_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_COMMIT = 2'd1,
        KIND_SORT   = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_NOREC  = 2'd2,
        STAT_UNUSED = 2'd3
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              which_string;
        logic [RECF_W-1:0] record;
        logic [POSF_W-1:0] position;
        logic [BYTE_W-1:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_byte;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // access bundle for the slot map
    typedef struct packed {
        logic [REC_W-1:0] rd_a;
        logic [REC_W-1:0] rd_b;
        logic             we;
        logic [REC_W-1:0] wr_addr;
        logic [REC_W-1:0] wr_data;
    } t_map_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOT,
        ST_MEM,
        ST_DONE,
        ST_S_FETCH,
        ST_S_LATCH,
        ST_S_BYTE,
        ST_S_CHK,
        ST_S_SWAP1,
        ST_S_SWAP2,
        ST_S_NEXT
    } t_state;

endpackage

FILE: sv/tksr_in_if.sv
// request channel interface
interface tksr_in_if;
    import tksr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: sv/tksr_out_if.sv
// result channel interface
interface tksr_out_if;
    import tksr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: sv/tksr_ram.sv
// generic byte store: one write port, two registered read ports
module tksr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

FILE: sv/tksr_map.sv
// slot map: list position to physical record slot, identity after reset
module tksr_map (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tksr_pkg::t_map_req        i_req,
    output logic [tksr_pkg::REC_W-1:0] o_slot_a,
    output logic [tksr_pkg::REC_W-1:0] o_slot_b
);
    import tksr_pkg::*;

    logic [REC_W-1:0]       r_mem [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] r_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // written marks, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // registered reads, an unwritten entry maps to itself
    always_ff @(posedge i_clk) begin
        o_slot_a <= r_valid[i_req.rd_a] ? r_mem[i_req.rd_a] : i_req.rd_a;
        o_slot_b <= r_valid[i_req.rd_b] ? r_mem[i_req.rd_b] : i_req.rd_b;
    end
endmodule

FILE: sv/two_key_string_record_sorter.sv
// top level: request sequencer, slot map and the two string stores
//
//  channel  dir  payload                                   handshake
//  i_in     in   kind, which_string, record, position, ch  valid/ready
//  o_out    out  read_byte, count, status                  valid/ready
//
// commit goes to the result state, write via the slot state, read via slot and memory;
// a full write, an uncommitted read and a sort of fewer than two records go to the result.
// sort runs a shaker sort over the slot map: each pair fetches its slots, then byte pairs
// from the stores are compared; an exchange adds 2 map writes. One request at a time.
// a new request is taken while the previous result waits in the output register.
// reset (synchronous, low) clears the state, result valid, record count and slot map marks.
module two_key_string_record_sorter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tksr_in_if.sink    i_in,
    tksr_out_if.source o_out
);
    import tksr_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_in_item         r_item, n_item;
    logic [BYTE_W-1:0] r_byte, n_byte;
    t_status          r_status, n_status;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic [REC_W-1:0] r_lo, n_lo, r_hi, n_hi, r_a, n_a;
    logic [REC_W-1:0] r_slot_a, n_slot_a, r_slot_b, n_slot_b;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_fwd, n_fwd, r_swapped, n_swapped, r_key_art, n_key_art;

    t_map_req          map_req;
    logic [REC_W-1:0]  map_a, map_b;
    logic [ADDR_W-1:0] ram_ra, ram_rb, ram_wa;
    logic              we_title, we_artist;
    logic [BYTE_W-1:0] tit_a, tit_b, art_a, art_b, cmp_x, cmp_y;
    logic              full, pos_ok;
    logic [REC_W:0]    a_plus, lo_plus;

    tksr_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (map_req),
        .o_slot_a (map_a),
        .o_slot_b (map_b)
    );

    tksr_ram #(.DEPTH(STORE_DEPTH), .WIDTH(BYTE_W)) u_title (
        .i_clk     (i_clk),
        .i_we      (we_title),
        .i_waddr   (ram_wa),
        .i_wdata   (r_item.ch),
        .i_raddr_a (ram_ra),
        .i_raddr_b (ram_rb),
        .o_rdata_a (tit_a),
        .o_rdata_b (tit_b)
    );

    tksr_ram #(.DEPTH(STORE_DEPTH), .WIDTH(BYTE_W)) u_artist (
        .i_clk     (i_clk),
        .i_we      (we_artist),
        .i_waddr   (ram_wa),
        .i_wdata   (r_item.ch),
        .i_raddr_a (ram_ra),
        .i_raddr_b (ram_rb),
        .o_rdata_a (art_a),
        .o_rdata_b (art_b)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    assign full    = (r_count >= CNT_W'(MAX_RECORDS));
    assign pos_ok  = (int'(r_item.position) < MAX_CHARS);
    assign cmp_x   = r_key_art ? art_a : tit_a;
    assign cmp_y   = r_key_art ? art_b : tit_b;
    assign a_plus  = {1'b0, r_a} + 1'b1;
    assign lo_plus = {1'b0, r_lo} + 1'b1;

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_byte    <= n_byte;
        r_status  <= n_status;
        r_out     <= n_out;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_a       <= n_a;
        r_slot_a  <= n_slot_a;
        r_slot_b  <= n_slot_b;
        r_pos     <= n_pos;
        r_fwd     <= n_fwd;
        r_swapped <= n_swapped;
        r_key_art <= n_key_art;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_item      = r_item;
        n_byte      = r_byte;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_a         = r_a;
        n_slot_a    = r_slot_a;
        n_slot_b    = r_slot_b;
        n_pos       = r_pos;
        n_fwd       = r_fwd;
        n_swapped   = r_swapped;
        n_key_art   = r_key_art;
        map_req     = '0;
        map_req.rd_a = r_a;
        map_req.rd_b = a_plus[REC_W-1:0];
        ram_ra      = {r_slot_a, r_pos};
        ram_rb      = {r_slot_b, r_pos};
        ram_wa      = {map_a, POS_W'(r_item.position)};
        we_title    = 1'b0;
        we_artist   = 1'b0;

        // result leaves when taken
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                n_item   = i_in.item;
                n_byte   = '0;
                n_status = STAT_OK;
                map_req.rd_a = (t_kind'(i_in.item.kind) == KIND_READ)
                               ? REC_W'(i_in.item.record) : r_count[REC_W-1:0];
                if (i_in.valid) begin
                    case (t_kind'(i_in.item.kind))
                        KIND_WRITE: begin
                            if (full) begin
                                n_status = STAT_FULL;
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_SLOT;
                            end
                        end
                        KIND_COMMIT: begin
                            if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        KIND_SORT: begin
                            if (r_count < CNT_W'(2)) begin
                                n_state = ST_DONE;
                            end else begin
                                n_lo      = '0;
                                n_hi      = REC_W'(r_count - 1'b1);
                                n_a       = '0;
                                n_fwd     = 1'b1;
                                n_swapped = 1'b0;
                                n_state   = ST_S_FETCH;
                            end
                        end
                        KIND_READ: begin
                            if (CNT_W'(i_in.item.record) >= r_count) begin
                                n_status = STAT_NOREC;
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_SLOT;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            // physical slot known
            ST_SLOT: begin
                ram_ra = {map_a, POS_W'(r_item.position)};
                if (t_kind'(r_item.kind) == KIND_WRITE) begin
                    we_title  = pos_ok && !r_item.which_string;
                    we_artist = pos_ok && r_item.which_string;
                    n_state   = ST_DONE;
                end else begin
                    n_state = ST_MEM;
                end
            end
            // latch the read byte
            ST_MEM: begin
                if (pos_ok) begin
                    n_byte = r_item.which_string ? art_a : tit_a;
                end
                n_state = ST_DONE;
            end
            // hand the result to the output register
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.read_byte = r_byte;
                    n_out.count     = COUNT_W'(r_count);
                    n_out.status    = r_status;
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            // fetch slots of pair a, a+1
            ST_S_FETCH: n_state = ST_S_LATCH;
            ST_S_LATCH: begin
                n_slot_a  = map_a;
                n_slot_b  = map_b;
                n_pos     = '0;
                n_key_art = 1'b1;
                n_state   = ST_S_BYTE;
            end
            ST_S_BYTE: n_state = ST_S_CHK;
            // byte compare, artist first then title
            ST_S_CHK: begin
                if (cmp_x != cmp_y) begin
                    n_state = (cmp_x > cmp_y) ? ST_S_SWAP1 : ST_S_NEXT;
                end else if (cmp_x == '0 || r_pos == POS_W'(MAX_CHARS - 1)) begin
                    if (r_key_art) begin
                        n_key_art = 1'b0;
                        n_pos     = '0;
                        n_state   = ST_S_BYTE;
                    end else begin
                        n_state = ST_S_NEXT;
                    end
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = ST_S_BYTE;
                end
            end
            // exchange map entries
            ST_S_SWAP1: begin
                map_req.we      = 1'b1;
                map_req.wr_addr = r_a;
                map_req.wr_data = r_slot_b;
                n_state         = ST_S_SWAP2;
            end
            ST_S_SWAP2: begin
                map_req.we      = 1'b1;
                map_req.wr_addr = a_plus[REC_W-1:0];
                map_req.wr_data = r_slot_a;
                n_swapped       = 1'b1;
                n_state         = ST_S_NEXT;
            end
            // advance pair, pass and bounds
            ST_S_NEXT: begin
                n_state = ST_S_FETCH;
                if (r_fwd && (a_plus < {1'b0, r_hi})) begin
                    n_a = a_plus[REC_W-1:0];
                end else if (r_fwd && ((r_hi - 1'b1) > r_lo)) begin
                    n_hi  = r_hi - 1'b1;
                    n_fwd = 1'b0;
                    n_a   = r_hi - 2'd2;
                end else if (!r_fwd && (r_a > r_lo)) begin
                    n_a = r_a - 1'b1;
                end else begin
                    // end of backward pass, or of a forward pass with no backward pass left
                    if (r_fwd) begin
                        n_hi = r_hi - 1'b1;
                    end
                    n_lo = lo_plus[REC_W-1:0];
                    if (!r_swapped || (lo_plus >= {1'b0, n_hi})) begin
                        n_state = ST_DONE;
                    end else begin
                        n_swapped = 1'b0;
                        n_fwd     = 1'b1;
                        n_a       = lo_plus[REC_W-1:0];
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
